// File: src/servo_slew_duty_controller_defines.svh
// Assertion macros used by the servo slew duty controller back end.
`ifndef SERVO_SLEW_DUTY_CONTROLLER_DEFINES_SVH
`define SERVO_SLEW_DUTY_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSDC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ssdc assertion failed");

// Next-cycle implication, disabled during reset.
`define SSDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ssdc assertion failed");

`endif

// File: src/ssdc_pkg.sv
// Shared types and constants of the servo slew duty controller.
`default_nettype none

package ssdc_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] ANGLE_MAX = 8'd180;
    localparam logic [9:0] DUTY_MAX  = 10'd1023;

    // Register reset values
    localparam logic [5:0] STEP_SIZE_RST   = 6'd3;
    localparam logic [9:0] DUTY_OFFSET_RST = 10'd37;
    localparam logic [9:0] DUTY_SPAN_RST   = 10'd111;

    // Register indexes on the config port
    localparam logic [1:0] CFG_STEP_SIZE   = 2'd0;
    localparam logic [1:0] CFG_DUTY_OFFSET = 2'd1;
    localparam logic [1:0] CFG_DUTY_SPAN   = 2'd2;

    // Input command kinds
    localparam logic CMD_SET_ANGLE = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    // x/180 = (x>>2)/45; (x>>2)/45 = ((x>>2)*46604)>>21, exact for x>>2 below 74898
    localparam int          PROD1_W   = 18;
    localparam int          PROD2_W   = 32;
    localparam int          DIV_SHIFT = 21;
    localparam logic [15:0] DIV_MULT  = 16'd46604;

    typedef struct packed {
        logic       is_tick;
        logic       ch_ok;
        logic [2:0] channel;
        logic [7:0] angle;     // already clamped
    } t_cmd;

    typedef struct packed {
        logic [5:0] step_size;
        logic [9:0] duty_offset;
        logic [9:0] duty_span;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/ssdc_front.sv
// Front end: takes input transfers, classifies and clamps them into a command register.
`default_nettype none

module ssdc_front import ssdc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_command,
    input  wire logic [2:0] i_channel,
    input  wire logic [7:0] i_angle,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_ready
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd w_cls;

    always_comb begin
        w_cls.is_tick = (i_command == CMD_TICK);
        w_cls.ch_ok   = ({29'd0, i_channel} < 32'(NUM_CHANNELS));
        w_cls.channel = i_channel;
        w_cls.angle   = (i_angle > ANGLE_MAX) ? ANGLE_MAX : i_angle;
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= w_cls;
        end
    end

endmodule

`default_nettype wire

// File: src/ssdc_queue.sv
// Short command FIFO between front end and back end.
`default_nettype none

module ssdc_queue import ssdc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/ssdc_back.sv
// Back end: target computation, per-channel slew sweep and result register.
`default_nettype none

module ssdc_back import ssdc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_q_cmd,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_out_channel,
    output logic [9:0]      o_duty,
    output logic            o_settled,
    output logic            o_last
);

`include "servo_slew_duty_controller_defines.svh"

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int QUOT_W = PROD2_W - DIV_SHIFT;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_ADD, S_SWEEP} t_state;

    t_state               r_state, n_state;
    logic [9:0]           r_cur [NUM_CHANNELS];
    logic [9:0]           r_tgt [NUM_CHANNELS];
    logic [CH_W-1:0]      r_ch, n_ch;
    logic [CH_W-1:0]      r_idx;
    logic [PROD1_W-1:0]   r_prod1;
    logic [PROD2_W-1:0]   r_prod2;
    logic                 r_out_valid;
    logic [2:0]           r_out_channel;
    logic [9:0]           r_duty;
    logic                 r_settled;
    logic                 r_last;

    logic                 w_slot_free;
    logic                 w_load;
    logic                 w_last;
    logic                 w_set_go;
    logic [CH_W+2:0]      w_cmd_ext;
    logic [CH_W+2:0]      w_cnt_ext;
    logic [PROD1_W-1:0]   w_prod1;
    logic [PROD2_W-1:0]   w_prod2;
    logic [QUOT_W-1:0]    w_quot;
    logic [10:0]          w_sum;
    logic [9:0]           w_target;
    logic [9:0]           w_cur;
    logic [9:0]           w_tgt;
    logic [9:0]           w_step;
    logic [9:0]           w_new;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign w_set_go    = o_q_pop && !i_q_cmd.is_tick && i_q_cmd.ch_ok;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_load      = (r_state == S_SWEEP) && w_slot_free;
    assign w_last      = (r_ch == CH_W'(NUM_CHANNELS - 1));

    assign w_cmd_ext = {{CH_W{1'b0}}, i_q_cmd.channel};
    assign w_cnt_ext = {3'b000, r_ch};

    // angle*span, then divide by 180 through the reciprocal
    assign w_prod1  = {10'd0, i_q_cmd.angle} * {8'd0, i_cfg.duty_span};
    assign w_prod2  = {16'd0, r_prod1[PROD1_W-1:2]} * {16'd0, DIV_MULT};
    assign w_quot   = r_prod2[PROD2_W-1:DIV_SHIFT];
    assign w_sum    = {1'b0, i_cfg.duty_offset} + 11'(w_quot);
    assign w_target = (w_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : w_sum[9:0];

    // slew unit, one channel per cycle while the result slot is free
    assign w_cur  = r_cur[r_ch];
    assign w_tgt  = r_tgt[r_ch];
    assign w_step = {4'd0, i_cfg.step_size};

    always_comb begin
        priority if (w_cur > w_tgt) begin
            w_new = ((w_cur - w_tgt) <= w_step) ? w_tgt : w_cur - w_step;
        end else if (w_cur < w_tgt) begin
            w_new = ((w_tgt - w_cur) <= w_step) ? w_tgt : w_cur + w_step;
        end else begin
            w_new = w_cur;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    if (i_q_cmd.is_tick) begin
                        n_state = S_SWEEP;
                        n_ch    = '0;
                    end else if (i_q_cmd.ch_ok) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV:   n_state = S_ADD;
            S_ADD:   n_state = S_IDLE;
            S_SWEEP: begin
                if (w_load) begin
                    n_ch = r_ch + 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= DUTY_OFFSET_RST;
            end
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_cur[r_ch]  <= w_new;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ADD) begin
                r_tgt[r_idx] <= w_target;
            end
        end
        if (w_set_go) begin
            r_prod1 <= w_prod1;
            r_idx   <= w_cmd_ext[CH_W-1:0];
        end
        if (r_state == S_DIV) begin
            r_prod2 <= w_prod2;
        end
        if (w_load) begin
            r_out_channel <= w_cnt_ext[2:0];
            r_duty        <= w_new;
            r_settled     <= (w_new == w_tgt);
            r_last        <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_duty        = r_duty;
    assign o_settled     = r_settled;
    assign o_last        = r_last;

    `SSDC_ASSERT_IMPLY(a_sweep_in_range, i_clk, i_rst_n, r_state == S_SWEEP, 32'(r_ch) < 32'(NUM_CHANNELS))
    `SSDC_ASSERT_NEXT(a_last_ends_sweep, i_clk, i_rst_n, w_load && w_last, r_state == S_IDLE)
    `SSDC_ASSERT_NEXT(a_set_chain, i_clk, i_rst_n, r_state == S_DIV, r_state == S_ADD)

endmodule

`default_nettype wire

// File: src/servo_slew_duty_controller.sv
// Top level of the servo slew duty controller: ports, register file and block wiring.
//
// Servo slew duty controller. Each input transfer is either a set_angle command (tuser = 0),
// which clamps the angle to 180 and stores target = offset + angle*span/180 (truncated,
// saturated at 1023) for one channel, or a tick (tuser = 1), which moves every channel's duty
// toward its target by step_size, landing on the target when within one step, and emits one
// result per channel in ascending order with tlast on the final channel. The front end takes
// a transfer every cycle while its command queue has room. In the back end a set_angle passes
// through multiply, reciprocal multiply for the divide by 180, then add and saturate; a
// set_angle to a channel out of range is taken from the queue and changes nothing. A tick is
// taken from the queue, then each channel in turn goes through the single slew unit; a
// stalled result holds the sweep. The user must write registers through the config port only
// while no command is in flight; the block does not enforce this. Offset and span only affect
// later set_angle commands. No clearing pass runs after reset.
`default_nettype none

module servo_slew_duty_controller import ssdc_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // [2:0] channel, [10:3] angle, [15:11] zero
    input  wire logic [0:0]  i_s_tuser,  // [0] command
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // [2:0] out_channel, [12:3] duty, [20:13] duty_high,
                                         // [22:21] duty_low, [23] settled
    output logic             o_m_tlast,
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);

    t_cfg       r_cfg;

    logic       w_front_valid;
    t_cmd       w_front_cmd;
    logic       w_q_ready;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_q_pop;
    logic [2:0] w_out_channel;
    logic [9:0] w_duty;
    logic       w_settled;

    // Register file; writes are always taken, unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size   <= STEP_SIZE_RST;
            r_cfg.duty_offset <= DUTY_OFFSET_RST;
            r_cfg.duty_span   <= DUTY_SPAN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP_SIZE:   r_cfg.step_size   <= i_cfg_data[5:0];
                CFG_DUTY_OFFSET: r_cfg.duty_offset <= i_cfg_data;
                CFG_DUTY_SPAN:   r_cfg.duty_span   <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // Front end: classify and clamp each transfer
    ssdc_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_command   (i_s_tuser[0]),
        .i_channel   (i_s_tdata[2:0]),
        .i_angle     (i_s_tdata[10:3]),
        .o_cmd_valid (w_front_valid),
        .o_cmd       (w_front_cmd),
        .i_cmd_ready (w_q_ready)
    );

    // Decoupling queue
    ssdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_cmd   (w_front_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // Back end: targets, slew sweep, result register
    ssdc_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out_channel (w_out_channel),
        .o_duty        (w_duty),
        .o_settled     (w_settled),
        .o_last        (o_m_tlast)
    );

    // duty_high and duty_low are plain slices of duty
    assign o_m_tdata = {w_settled, w_duty[1:0], w_duty[9:2], w_duty, w_out_channel};

endmodule

`default_nettype wire

// File: bench/servo_slew_duty_controller_tb.sv
// Self-checking bench for the servo slew duty controller: random command streams, duty ramp check.
module servo_slew_duty_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdc_pkg::*;

    localparam int NUM_CH        = NUM_CHANNELS_DEF;
    localparam int SEGMENTS      = 6;
    localparam int SEG_ITEMS     = 75;
    localparam int SETTLE_CYCLES = 16;     // set_angle pipe plus command queue, with margin
    localparam int HOLD_CYCLES   = 400;    // long result-side back-pressure
    localparam int CYCLE_LIMIT   = 300000;

    // index with no register behind it; writes must be dropped
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic       cmd;
        logic [2:0] channel;
        logic [7:0] angle;
    } servo_cmd_t;

    typedef struct {
        logic [2:0] out_channel;
        logic [9:0] duty;
        logic [7:0] duty_high;
        logic [1:0] duty_low;
        logic       settled;
        logic       last;
    } duty_report_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;   // [2:0] channel, [10:3] angle, [15:11] zero
    logic [0:0]  i_s_tuser   = '0;   // [0] command
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;          // [2:0] out_channel, [12:3] duty, [20:13] duty_high,
                                     // [22:21] duty_low, [23] settled
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data  = '0;

    servo_slew_duty_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------------
    // Duty predictor: own copy of registers and per-channel duty state
    // ---------------------------------------------------------------------------------------
    logic [5:0] cfg_step   = STEP_SIZE_RST;
    logic [9:0] cfg_offset = DUTY_OFFSET_RST;
    logic [9:0] cfg_span   = DUTY_SPAN_RST;
    logic [9:0] chan_duty   [NUM_CH];
    logic [9:0] chan_target [NUM_CH];

    servo_cmd_t   servo_cmds_pending[$];   // filled by the stimulus, drained by the driver
    duty_report_t duty_reports_due[$];     // per-channel reports still owed by the block

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;                 // bumped by stimulus to ask for one long stall
    int mismatch_count = 0;

    initial begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            chan_duty[ch]   = '0;
            chan_target[ch] = DUTY_OFFSET_RST;   // angle zero at reset offset
        end
    end

    // offset + clamp(angle)*span/180, truncated, saturated at full scale
    function automatic logic [9:0] angle_target(input logic [7:0] angle);
        int a;
        int sum;
        a   = (angle > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(angle);
        sum = int'(cfg_offset) + (a * int'(cfg_span)) / int'(ANGLE_MAX);
        return (sum > int'(DUTY_MAX)) ? DUTY_MAX : 10'(sum);
    endfunction

    // one tick of approach; lands on target when within a step, step 0 holds
    function automatic logic [9:0] slew_toward(input logic [9:0] cur, input logic [9:0] tgt);
        int c;
        int t;
        int s;
        c = cur;
        t = tgt;
        s = cfg_step;
        if (c > t)
            return (c - t <= s) ? tgt : 10'(c - s);
        if (c < t)
            return (t - c <= s) ? tgt : 10'(c + s);
        return cur;
    endfunction

    function automatic void apply_servo_cmd(input servo_cmd_t c);
        duty_report_t r;
        if (c.cmd == CMD_SET_ANGLE) begin
            // channels past the last one are dropped silently
            if (c.channel < NUM_CH)
                chan_target[c.channel] = angle_target(c.angle);
        end else begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                chan_duty[ch] = slew_toward(chan_duty[ch], chan_target[ch]);
                r.out_channel = 3'(ch);
                r.duty        = chan_duty[ch];
                r.duty_high   = chan_duty[ch][9:2];
                r.duty_low    = chan_duty[ch][1:0];
                r.settled     = (chan_duty[ch] == chan_target[ch]);
                r.last        = (ch == NUM_CH - 1);
                duty_reports_due.push_back(r);
            end
        end
    endfunction

    // ---------------------------------------------------------------------------------------
    // Command driver: one transfer per handshake, random gaps per send_idle_pct
    // ---------------------------------------------------------------------------------------
    servo_cmd_t drv_cmd;
    servo_cmd_t head_cmd;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                apply_servo_cmd(drv_cmd);
            if (!i_s_tvalid || o_s_tready) begin
                if (servo_cmds_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    head_cmd = servo_cmds_pending.pop_front();
                    drv_cmd    <= head_cmd;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {5'b0, head_cmd.angle, head_cmd.channel};
                    i_s_tuser  <= head_cmd.cmd;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Result monitor and tready generation
    // ---------------------------------------------------------------------------------------
    int hold_served = 0;
    int hold_left   = 0;

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t ERROR %s mismatch: expected %0d, actual %0d", $time, name, exp_v,
                     got_v);
            mismatch_count++;
        end
    endfunction

    function automatic void check_report();
        duty_report_t exp_r;
        if (duty_reports_due.size() == 0) begin
            $display("%0t ERROR unexpected result: expected none, actual tdata %h tlast %b",
                     $time, o_m_tdata, o_m_tlast);
            mismatch_count++;
            return;
        end
        exp_r = duty_reports_due.pop_front();
        check_field("out_channel", exp_r.out_channel, o_m_tdata[2:0]);
        check_field("duty",        exp_r.duty,        o_m_tdata[12:3]);
        check_field("duty_high",   exp_r.duty_high,   o_m_tdata[20:13]);
        check_field("duty_low",    exp_r.duty_low,    o_m_tdata[22:21]);
        check_field("settled",     exp_r.settled,     o_m_tdata[23]);
        check_field("last",        exp_r.last,        o_m_tlast);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                check_report();
            if (hold_served != hold_request) begin
                hold_served <= hold_request;
                hold_left   <= HOLD_CYCLES;
                i_m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL servo_slew_duty_controller");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP_SIZE:   cfg_step   = val[5:0];
            CFG_DUTY_OFFSET: cfg_offset = val;
            CFG_DUTY_SPAN:   cfg_span   = val;
            default: ;
        endcase
    endtask

    // sender holds off until the block has nothing left in flight; sampled mid-cycle so
    // the driver's updates at the rising edge are already visible
    task automatic wait_idle();
        do @(negedge i_clk);
        while (servo_cmds_pending.size() != 0 || i_s_tvalid || duty_reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_cmd(input logic cmd, input logic [2:0] channel,
                             input logic [7:0] angle);
        servo_cmd_t c;
        c.cmd     = cmd;
        c.channel = channel;
        c.angle   = angle;
        servo_cmds_pending.push_back(c);
    endtask

    // mostly set_angle to valid channels; some ticks, stray channels and edge angles
    task automatic queue_random_cmd();
        logic [2:0] channel;
        logic [7:0] angle;
        channel = ($urandom_range(99) < 10) ? 3'($urandom_range(7, NUM_CH))
                                            : 3'($urandom_range(NUM_CH - 1));
        case ($urandom_range(9))
            0:       angle = 8'd0;
            1:       angle = ANGLE_MAX;
            2:       angle = ANGLE_MAX + 8'd1;
            3:       angle = 8'd255;
            default: angle = 8'($urandom_range(255));
        endcase
        if ($urandom_range(99) < 35)
            queue_cmd(CMD_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)));
        else
            queue_cmd(CMD_SET_ANGLE, channel, angle);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset registers: edge angles, stray channels, first ticks from zero duty
        queue_cmd(CMD_SET_ANGLE, 3'd0, 8'd0);
        queue_cmd(CMD_SET_ANGLE, 3'd1, ANGLE_MAX);
        queue_cmd(CMD_SET_ANGLE, 3'd2, 8'd255);
        queue_cmd(CMD_SET_ANGLE, 3'd3, 8'd90);
        queue_cmd(CMD_SET_ANGLE, 3'd4, ANGLE_MAX + 8'd1);
        queue_cmd(CMD_SET_ANGLE, 3'd5, 8'd1);
        queue_cmd(CMD_SET_ANGLE, 3'd6, 8'd77);
        queue_cmd(CMD_SET_ANGLE, 3'd7, 8'd200);
        repeat (3) queue_cmd(CMD_TICK, 3'd0, 8'd0);
        wait_idle();

        // max step, target saturation; stored targets survive the offset/span change
        write_reg(CFG_DUTY_OFFSET, 10'd1023);
        write_reg(CFG_DUTY_SPAN, 10'd1023);
        write_reg(CFG_STEP_SIZE, 10'd1023);
        write_reg(CFG_UNUSED, 10'd1023);
        queue_cmd(CMD_SET_ANGLE, 3'd0, ANGLE_MAX);
        queue_cmd(CMD_SET_ANGLE, 3'd1, 8'd0);
        repeat (2) queue_cmd(CMD_TICK, 3'd7, 8'd255);
        wait_idle();

        // step field wraps to zero: duties freeze unless already on target
        write_reg(CFG_STEP_SIZE, 10'd64);
        write_reg(CFG_DUTY_OFFSET, 10'd0);
        write_reg(CFG_DUTY_SPAN, 10'd0);
        queue_cmd(CMD_SET_ANGLE, 3'd2, 8'd255);
        repeat (2) queue_cmd(CMD_TICK, 3'd0, 8'd0);
        wait_idle();

        // random segments: first receiver-heavy idling, then sender-heavy, then none
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                1: begin
                    write_reg(CFG_STEP_SIZE, 10'd1);
                    write_reg(CFG_DUTY_OFFSET, 10'd0);
                    write_reg(CFG_DUTY_SPAN, 10'd1023);
                end
                2: begin
                    write_reg(CFG_STEP_SIZE, 10'd63);
                    write_reg(CFG_DUTY_OFFSET, 10'd1023);
                    write_reg(CFG_DUTY_SPAN, 10'd1023);
                end
                3: begin
                    write_reg(CFG_STEP_SIZE, 10'd64);
                    write_reg(CFG_DUTY_OFFSET, 10'($urandom_range(1023)));
                    write_reg(CFG_DUTY_SPAN, 10'($urandom_range(1023)));
                end
                5: begin
                    write_reg(CFG_DUTY_OFFSET, 10'd0);
                    write_reg(CFG_DUTY_SPAN, 10'd0);
                    write_reg(CFG_STEP_SIZE, 10'($urandom_range(1023)));
                    write_reg(CFG_UNUSED, 10'($urandom_range(1023)));
                end
                default: begin
                    write_reg(CFG_STEP_SIZE, 10'($urandom_range(63, 1)));
                    write_reg(CFG_DUTY_OFFSET, 10'($urandom_range(1023)));
                    write_reg(CFG_DUTY_SPAN, 10'($urandom_range(1023)));
                end
            endcase

            if (seg < 2) begin
                send_idle_pct = 6;
                recv_idle_pct = 64;
            end else if (seg < 4) begin
                send_idle_pct = 64;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // long result stall while commands keep coming, so the input backs up
            if (seg == 0 || seg == 4)
                hold_request++;

            repeat (SEG_ITEMS) queue_random_cmd();
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS servo_slew_duty_controller");
        else
            $display("FAIL servo_slew_duty_controller");
        $finish;
    end

endmodule
